@@ rtl/utf8_stream_decoder_macros.svh @@
// Assertion macros shared by the UTF-8 stream decoder RTL.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTH
// Condition and consequence checked in the same cycle.
`define UTF8SD_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Consequence checked in the cycle after the condition.
`define UTF8SD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define UTF8SD_ASSERT_NOW(label, clk, rst_n, cond, prop, msg)
`define UTF8SD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif

`endif

@@ rtl/utf8sd_pkg.sv @@
// Types and constants of the UTF-8 stream decoder.
`default_nettype none
package utf8sd_pkg;

    localparam int BYTE_BITS = 8;
    localparam int CP_BITS   = 31;
    localparam int LEN_BITS  = 3;
    localparam int CNT_BITS  = 16;

    typedef enum logic [1:0] {
        KIND_CODEPOINT = 2'd0,
        KIND_END       = 2'd1,
        KIND_ERROR     = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [CP_BITS-1:0]   codepoint;
        logic [LEN_BITS-1:0]  seq_length;
        logic [CNT_BITS-1:0]  char_count;
    } result_t;

    localparam logic [1:0]          CONT_TAG   = 2'b10;
    localparam logic [CNT_BITS-1:0] COUNT_SAT  = 16'hFFFF;
    localparam logic [LEN_BITS-1:0] LEN_SINGLE = 3'd1;

endpackage
`default_nettype wire

@@ rtl/utf8sd_in_stage.sv @@
// Input register that holds one byte beat until the decode step takes it.
`default_nettype none
module utf8sd_in_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [utf8sd_pkg::BYTE_BITS-1:0] s_data_byte,
    input  wire logic                           advance,
    output logic                                held_valid,
    output logic [utf8sd_pkg::BYTE_BITS-1:0]    held_byte
);
    import utf8sd_pkg::*;

    logic                 valid_reg, valid_next;
    logic [BYTE_BITS-1:0] byte_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_data_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule
`default_nettype wire

@@ rtl/utf8sd_decode.sv @@
// Decode state and the per-byte step: lead classification and six-bit shift-or.
`default_nettype none
module utf8sd_decode #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             fire,
    input  wire logic [utf8sd_pkg::BYTE_BITS-1:0] data_byte,
    output logic                                  emit,
    output utf8sd_pkg::result_t                   result
);
    import utf8sd_pkg::*;

    logic [CP_BITS-1:0]    acc_reg, acc_next;
    logic [LEN_BITS-1:0]   remain_reg, remain_next;
    logic [LEN_BITS-1:0]   size_reg, size_next;
    logic [COUNT_BITS-1:0] tally_reg, tally_next;
    logic                  skip_reg, skip_next;

    logic [31:0]           tally_wide;
    logic [COUNT_BITS-1:0] tally_bumped;
    logic [CP_BITS-1:0]    acc_shifted;

    assign tally_wide   = 32'(tally_reg);
    assign tally_bumped = (tally_reg == {COUNT_BITS{1'b1}}) ? tally_reg
                                                            : tally_reg + 1'b1;
    assign acc_shifted  = {acc_reg[CP_BITS-7:0], data_byte[5:0]};

    always_comb begin
        acc_next    = acc_reg;
        remain_next = remain_reg;
        size_next   = size_reg;
        tally_next  = tally_reg;
        skip_next   = skip_reg;
        emit        = 1'b0;
        result      = '0;
        result.kind = KIND_CODEPOINT;

        if (fire) begin
            if (skip_reg) begin
                if (data_byte == '0) begin
                    acc_next    = '0;
                    remain_next = '0;
                    size_next   = '0;
                    tally_next  = '0;
                    skip_next   = 1'b0;
                end
            end else if (remain_reg == '0) begin
                if (data_byte == '0) begin
                    emit              = 1'b1;
                    result.kind       = KIND_END;
                    result.char_count = (tally_wide > 32'(COUNT_SAT)) ? COUNT_SAT
                                                                      : tally_wide[15:0];
                    acc_next    = '0;
                    size_next   = '0;
                    tally_next  = '0;
                end else if (!data_byte[7]) begin
                    emit              = 1'b1;
                    result.codepoint  = {{(CP_BITS-BYTE_BITS){1'b0}}, data_byte};
                    result.seq_length = LEN_SINGLE;
                    tally_next        = tally_bumped;
                end else begin
                    unique casez (data_byte)
                        8'b110?????: begin
                            acc_next  = {{(CP_BITS-5){1'b0}}, data_byte[4:0]};
                            size_next = 3'd2;
                        end
                        8'b1110????: begin
                            acc_next  = {{(CP_BITS-4){1'b0}}, data_byte[3:0]};
                            size_next = 3'd3;
                        end
                        8'b11110???: begin
                            acc_next  = {{(CP_BITS-3){1'b0}}, data_byte[2:0]};
                            size_next = 3'd4;
                        end
                        8'b111110??: begin
                            acc_next  = {{(CP_BITS-2){1'b0}}, data_byte[1:0]};
                            size_next = 3'd5;
                        end
                        8'b1111110?: begin
                            acc_next  = {{(CP_BITS-1){1'b0}}, data_byte[0]};
                            size_next = 3'd6;
                        end
                        default: begin
                            // Stray continuation byte, 0xFE or 0xFF.
                            emit        = 1'b1;
                            result.kind = KIND_ERROR;
                            acc_next    = '0;
                            size_next   = '0;
                            tally_next  = '0;
                            skip_next   = 1'b1;
                        end
                    endcase
                    if (!skip_next) begin
                        remain_next = size_next - 1'b1;
                    end
                end
            end else if (data_byte[7:6] != CONT_TAG) begin
                // A zero here is swallowed by the error, so skipping waits for the next one.
                emit        = 1'b1;
                result.kind = KIND_ERROR;
                acc_next    = '0;
                remain_next = '0;
                size_next   = '0;
                tally_next  = '0;
                skip_next   = 1'b1;
            end else begin
                acc_next    = acc_shifted;
                remain_next = remain_reg - 1'b1;
                if (remain_reg == 3'd1) begin
                    emit              = 1'b1;
                    result.codepoint  = acc_shifted;
                    result.seq_length = size_reg;
                    tally_next        = tally_bumped;
                    acc_next          = '0;
                    size_next         = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            remain_reg <= '0;
            size_reg   <= '0;
            tally_reg  <= '0;
            skip_reg   <= 1'b0;
        end else begin
            acc_reg    <= acc_next;
            remain_reg <= remain_next;
            size_reg   <= size_next;
            tally_reg  <= tally_next;
            skip_reg   <= skip_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/utf8sd_out_stage.sv @@
// Result register that holds one result beat until the sink takes it.
`default_nettype none
module utf8sd_out_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire utf8sd_pkg::result_t load_result,
    output logic                     room,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output utf8sd_pkg::result_t      held_result
);
    import utf8sd_pkg::*;

    logic    valid_reg, valid_next;
    result_t result_reg;

    assign room = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

    assign m_valid     = valid_reg;
    assign held_result = result_reg;

endmodule
`default_nettype wire

@@ rtl/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder: input register, decode step, result register.
//
//  channel | direction | payload                                          | handshake
//  s_      | in        | data_byte[7:0]                                   | s_valid/s_ready
//  m_      | out       | result_kind, codepoint, seq_length, char_count   | m_valid/m_ready
//
// One byte is taken per cycle while the result register has room; a byte that ends a code point,
// a zero end or an error is decoded combinationally and loaded as it leaves the input register.
// Reset (aresetn low at a clock edge) clears both beat valid flags and all decode state.
// A stalled result register holds the input register, which then drops s_ready.
`default_nettype none
`include "utf8_stream_decoder_macros.svh"
module utf8_stream_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [utf8sd_pkg::BYTE_BITS-1:0] s_data_byte,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_result_kind,
    output logic [utf8sd_pkg::CP_BITS-1:0]        m_codepoint,
    output logic [utf8sd_pkg::LEN_BITS-1:0]       m_seq_length,
    output logic [utf8sd_pkg::CNT_BITS-1:0]       m_char_count
);
    import utf8sd_pkg::*;

    logic                 held_valid;
    logic [BYTE_BITS-1:0] held_byte;
    logic                 room;
    logic                 advance;
    logic                 emit;
    result_t              step_result;
    result_t              out_result;

    assign advance = held_valid && room;

    utf8sd_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .advance     (advance),
        .held_valid  (held_valid),
        .held_byte   (held_byte)
    );

    utf8sd_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .data_byte (held_byte),
        .emit      (emit),
        .result    (step_result)
    );

    utf8sd_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance && emit),
        .load_result (step_result),
        .room        (room),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .held_result (out_result)
    );

    assign m_result_kind = out_result.kind;
    assign m_codepoint   = out_result.codepoint;
    assign m_seq_length  = out_result.seq_length;
    assign m_char_count  = out_result.char_count;

    // A byte waiting on a full result register must stay put.
    `UTF8SD_ASSERT_NEXT(a_in_holds, aclk, aresetn, held_valid && !room, held_valid, "input beat lost while result stalled")
    `UTF8SD_ASSERT_NOW(a_cp_len, aclk, aresetn, m_valid && (m_result_kind == KIND_CODEPOINT), (m_seq_length != '0) && (m_char_count == '0), "codepoint beat has bad length or count")
    `UTF8SD_ASSERT_NOW(a_other_zero, aclk, aresetn, m_valid && (m_result_kind != KIND_CODEPOINT), (m_codepoint == '0) && (m_seq_length == '0), "non-codepoint beat carries codepoint data")
    `UTF8SD_ASSERT_NOW(a_err_zero, aclk, aresetn, m_valid && (m_result_kind == KIND_ERROR), m_char_count == '0, "error beat carries a count")

endmodule
`default_nettype wire
